// File: sv/i2cm_pkg.sv
// Package for the I2C master byte engine: item structs, command opcodes,
// configuration register indexes and reset values. No dependencies.
`default_nettype none

package i2cm_pkg;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    // Command opcodes carried in an input item
    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_STOP  = 3'd1;
    localparam logic [2:0] OP_SEND  = 3'd2;
    localparam logic [2:0] OP_WACK  = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_UNIT_CYCLES = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACK_TIMEOUT = 4'd1;

    localparam logic [15:0] UNIT_CYCLES_RST = 16'd100;
    localparam logic [15:0] ACK_TIMEOUT_RST = 16'd250;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] opcode;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_oe;
        logic       ready_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_missing;
    } out_item_t;

endpackage

`default_nettype wire

// File: sv/i2c_master_byte_engine.sv
// I2C master byte engine top level: timed bus sequencer plus output register.
// Depends on i2cm_pkg for item structs, opcodes and register indexes.
//
// Usage:
//   Every input item on s_* is one bus tick: the sampled SDA level plus an
//   optional command (start, stop, send byte, wait ack, read byte). Commands
//   are taken only while the engine is idle; others are ignored.
//   Each accepted item yields exactly one result item on m_*: the SCL/SDA
//   drive levels, SDA output enable, idle flag, a done pulse, the last
//   received byte and the ack-missing flag, all as they stand after the tick.
//   m_valid rises in the cycle after acceptance. While m_ready is high, one
//   item per cycle is sustained; the only stored path is sequencer state ->
//   result register. If m_ready is low while a result is held, s_ready drops
//   until it is taken; a result that is being taken frees the slot in the
//   same cycle. Bus phases last 4, 2 or 1 time units of unit_cycles ticks
//   each (register 0); register 1 sets the acknowledge timeout in units.
//   cfg_ready is always high; writes to other indexes are dropped.
//   Reset (aresetn low, synchronous) returns to idle with SCL and SDA high and
//   driven, clears the held byte and flags, and loads 100 and 250 into the
//   two registers.
`default_nettype none

module i2c_master_byte_engine (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output      logic                             s_ready,
    input  wire i2cm_pkg::in_item_t               s_data,
    output      logic                             m_valid,
    input  wire logic                             m_ready,
    output      i2cm_pkg::out_item_t              m_data,
    input  wire logic                             cfg_valid,
    output      logic                             cfg_ready,
    input  wire logic [i2cm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [i2cm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [4:0] PH_IDLE    = 5'd0;
    localparam logic [4:0] PH_ST_HIGH = 5'd1;
    localparam logic [4:0] PH_ST_LOW  = 5'd2;
    localparam logic [4:0] PH_SP_A    = 5'd3;
    localparam logic [4:0] PH_SP_B    = 5'd4;
    localparam logic [4:0] PH_SP_C    = 5'd5;
    localparam logic [4:0] PH_AK_LOW  = 5'd6;
    localparam logic [4:0] PH_AK_HIGH = 5'd7;
    localparam logic [4:0] PH_AK_POLL = 5'd8;
    localparam logic [4:0] PH_AK_END  = 5'd9;
    localparam logic [4:0] PH_TX_SET  = 5'd10;
    localparam logic [4:0] PH_TX_HIGH = 5'd11;
    localparam logic [4:0] PH_TX_LOW  = 5'd12;
    localparam logic [4:0] PH_RX_LOW  = 5'd13;
    localparam logic [4:0] PH_RX_HIGH = 5'd14;
    localparam logic [4:0] PH_RA_LOW  = 5'd15;
    localparam logic [4:0] PH_RA_HIGH = 5'd16;

    logic [15:0] unit_cycles_reg;
    logic [15:0] ack_timeout_reg;

    logic [4:0]  phase_reg, phase_next;
    logic [15:0] unit_counter_reg, unit_counter_next;
    logic [2:0]  step_units_reg, step_units_next;
    logic [3:0]  bit_index_reg, bit_index_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [15:0] timeout_counter_reg, timeout_counter_next;
    logic        ack_choice_reg, ack_choice_next;
    logic        scl_level_reg, scl_level_next;
    logic        sda_level_reg, sda_level_next;
    logic        sda_enable_reg, sda_enable_next;
    logic [7:0]  rx_hold_reg, rx_hold_next;
    logic        miss_flag_reg, miss_flag_next;
    logic        done_flag;

    logic                m_valid_reg;
    i2cm_pkg::out_item_t m_data_reg;

    logic        s_fire;
    logic [15:0] unit_inc;
    logic        unit_tick;
    logic [2:0]  step_dec;
    logic        expired;
    logic [3:0]  bit_inc;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Unit timing shared by all timed phases
    assign unit_inc  = unit_counter_reg + 16'd1;
    assign unit_tick = (unit_inc >= unit_cycles_reg) || (unit_cycles_reg == 16'd0);
    assign step_dec  = (step_units_reg != 3'd0) ? step_units_reg - 3'd1 : step_units_reg;
    assign expired   = unit_tick && (step_dec == 3'd0);
    assign bit_inc   = bit_index_reg + 4'd1;

    always_comb begin
        phase_next           = phase_reg;
        unit_counter_next    = unit_counter_reg;
        step_units_next      = step_units_reg;
        bit_index_next       = bit_index_reg;
        shift_byte_next      = shift_byte_reg;
        timeout_counter_next = timeout_counter_reg;
        ack_choice_next      = ack_choice_reg;
        scl_level_next       = scl_level_reg;
        sda_level_next       = sda_level_reg;
        sda_enable_next      = sda_enable_reg;
        rx_hold_next         = rx_hold_reg;
        miss_flag_next       = miss_flag_reg;
        done_flag            = 1'b0;

        if (phase_reg == PH_IDLE) begin
            if (s_data.cmd_valid) begin
                case (s_data.opcode)
                    i2cm_pkg::OP_START: begin
                        sda_enable_next   = 1'b1;
                        sda_level_next    = 1'b1;
                        scl_level_next    = 1'b1;
                        phase_next        = PH_ST_HIGH;
                        step_units_next   = 3'd4;
                        unit_counter_next = 16'd0;
                    end
                    i2cm_pkg::OP_STOP: begin
                        sda_enable_next   = 1'b1;
                        scl_level_next    = 1'b0;
                        sda_level_next    = 1'b0;
                        phase_next        = PH_SP_A;
                        step_units_next   = 3'd4;
                        unit_counter_next = 16'd0;
                    end
                    i2cm_pkg::OP_SEND: begin
                        shift_byte_next   = s_data.tx_byte;
                        bit_index_next    = 4'd0;
                        sda_enable_next   = 1'b1;
                        scl_level_next    = 1'b0;
                        sda_level_next    = s_data.tx_byte[7];
                        phase_next        = PH_TX_SET;
                        step_units_next   = 3'd2;
                        unit_counter_next = 16'd0;
                    end
                    i2cm_pkg::OP_WACK: begin
                        miss_flag_next    = 1'b0;
                        sda_enable_next   = 1'b0;
                        scl_level_next    = 1'b0;
                        sda_level_next    = 1'b1;
                        phase_next        = PH_AK_LOW;
                        step_units_next   = 3'd1;
                        unit_counter_next = 16'd0;
                    end
                    i2cm_pkg::OP_READ: begin
                        ack_choice_next   = s_data.send_ack;
                        bit_index_next    = 4'd0;
                        shift_byte_next   = 8'd0;
                        sda_enable_next   = 1'b0;
                        scl_level_next    = 1'b0;
                        phase_next        = PH_RX_LOW;
                        step_units_next   = 3'd2;
                        unit_counter_next = 16'd0;
                    end
                    default: begin
                    end
                endcase
            end
        end else if (phase_reg == PH_AK_POLL) begin
            if (!s_data.sda_in) begin
                scl_level_next    = 1'b0;
                phase_next        = PH_AK_END;
                step_units_next   = 3'd1;
                unit_counter_next = 16'd0;
            end else begin
                unit_counter_next = unit_tick ? 16'd0 : unit_inc;
                if (unit_tick) begin
                    if (timeout_counter_reg >= ack_timeout_reg) begin
                        // gave up: flag it and release the bus with a stop
                        miss_flag_next    = 1'b1;
                        sda_enable_next   = 1'b1;
                        scl_level_next    = 1'b0;
                        sda_level_next    = 1'b0;
                        phase_next        = PH_SP_A;
                        step_units_next   = 3'd4;
                        unit_counter_next = 16'd0;
                    end else begin
                        timeout_counter_next = timeout_counter_reg + 16'd1;
                    end
                end
            end
        end else begin
            unit_counter_next = unit_tick ? 16'd0 : unit_inc;
            if (unit_tick) begin
                step_units_next = step_dec;
            end
            if (expired) begin
                case (phase_reg)
                    PH_ST_HIGH: begin
                        sda_level_next    = 1'b0;
                        phase_next        = PH_ST_LOW;
                        step_units_next   = 3'd4;
                        unit_counter_next = 16'd0;
                    end
                    PH_ST_LOW: begin
                        scl_level_next = 1'b0;
                        phase_next     = PH_IDLE;
                        done_flag      = 1'b1;
                    end
                    PH_SP_A: begin
                        scl_level_next    = 1'b1;
                        phase_next        = PH_SP_B;
                        step_units_next   = 3'd4;
                        unit_counter_next = 16'd0;
                    end
                    PH_SP_B: begin
                        sda_level_next    = 1'b1;
                        phase_next        = PH_SP_C;
                        step_units_next   = 3'd4;
                        unit_counter_next = 16'd0;
                    end
                    PH_SP_C: begin
                        phase_next = PH_IDLE;
                        done_flag  = 1'b1;
                    end
                    PH_AK_LOW: begin
                        scl_level_next    = 1'b1;
                        phase_next        = PH_AK_HIGH;
                        step_units_next   = 3'd1;
                        unit_counter_next = 16'd0;
                    end
                    PH_AK_HIGH: begin
                        phase_next           = PH_AK_POLL;
                        timeout_counter_next = 16'd0;
                        unit_counter_next    = 16'd0;
                    end
                    PH_AK_END: begin
                        phase_next = PH_IDLE;
                        done_flag  = 1'b1;
                    end
                    PH_TX_SET: begin
                        scl_level_next    = 1'b1;
                        phase_next        = PH_TX_HIGH;
                        step_units_next   = 3'd2;
                        unit_counter_next = 16'd0;
                    end
                    PH_TX_HIGH: begin
                        scl_level_next    = 1'b0;
                        phase_next        = PH_TX_LOW;
                        step_units_next   = 3'd2;
                        unit_counter_next = 16'd0;
                    end
                    PH_TX_LOW: begin
                        if (bit_inc >= 4'd8) begin
                            bit_index_next = 4'd0;
                            phase_next     = PH_IDLE;
                            done_flag      = 1'b1;
                        end else begin
                            bit_index_next    = bit_inc;
                            shift_byte_next   = {shift_byte_reg[6:0], 1'b0};
                            sda_level_next    = shift_byte_reg[6];
                            phase_next        = PH_TX_SET;
                            step_units_next   = 3'd2;
                            unit_counter_next = 16'd0;
                        end
                    end
                    PH_RX_LOW: begin
                        scl_level_next    = 1'b1;
                        shift_byte_next   = {shift_byte_reg[6:0], s_data.sda_in};
                        phase_next        = PH_RX_HIGH;
                        step_units_next   = 3'd1;
                        unit_counter_next = 16'd0;
                    end
                    PH_RX_HIGH: begin
                        scl_level_next    = 1'b0;
                        step_units_next   = 3'd2;
                        unit_counter_next = 16'd0;
                        if (bit_inc >= 4'd8) begin
                            // byte complete: drive the ACK/NACK bit
                            bit_index_next  = 4'd0;
                            rx_hold_next    = shift_byte_reg;
                            sda_enable_next = 1'b1;
                            sda_level_next  = !ack_choice_reg;
                            phase_next      = PH_RA_LOW;
                        end else begin
                            bit_index_next = bit_inc;
                            phase_next     = PH_RX_LOW;
                        end
                    end
                    PH_RA_LOW: begin
                        scl_level_next    = 1'b1;
                        phase_next        = PH_RA_HIGH;
                        step_units_next   = 3'd2;
                        unit_counter_next = 16'd0;
                    end
                    PH_RA_HIGH: begin
                        scl_level_next = 1'b0;
                        phase_next     = PH_IDLE;
                        done_flag      = 1'b1;
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_cycles_reg <= i2cm_pkg::UNIT_CYCLES_RST;
            ack_timeout_reg <= i2cm_pkg::ACK_TIMEOUT_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == i2cm_pkg::REG_UNIT_CYCLES) begin
                unit_cycles_reg <= cfg_data;
            end else if (cfg_index == i2cm_pkg::REG_ACK_TIMEOUT) begin
                ack_timeout_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_IDLE;
            unit_counter_reg    <= 16'd0;
            step_units_reg      <= 3'd0;
            bit_index_reg       <= 4'd0;
            shift_byte_reg      <= 8'd0;
            timeout_counter_reg <= 16'd0;
            ack_choice_reg      <= 1'b0;
            scl_level_reg       <= 1'b1;
            sda_level_reg       <= 1'b1;
            sda_enable_reg      <= 1'b1;
            rx_hold_reg         <= 8'd0;
            miss_flag_reg       <= 1'b0;
        end else if (s_fire) begin
            phase_reg           <= phase_next;
            unit_counter_reg    <= unit_counter_next;
            step_units_reg      <= step_units_next;
            bit_index_reg       <= bit_index_next;
            shift_byte_reg      <= shift_byte_next;
            timeout_counter_reg <= timeout_counter_next;
            ack_choice_reg      <= ack_choice_next;
            scl_level_reg       <= scl_level_next;
            sda_level_reg       <= sda_level_next;
            sda_enable_reg      <= sda_enable_next;
            rx_hold_reg         <= rx_hold_next;
            miss_flag_reg       <= miss_flag_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg.scl_out     <= scl_level_next;
            m_data_reg.sda_out     <= sda_level_next;
            m_data_reg.sda_oe      <= sda_enable_next;
            m_data_reg.ready_res   <= (phase_next == PH_IDLE);
            m_data_reg.done_res    <= done_flag;
            m_data_reg.rx_byte     <= rx_hold_next;
            m_data_reg.ack_missing <= miss_flag_next;
        end
    end

    a_fire_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_valid)
        else $error("accepted item produced no result");

    a_done_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.done_res) |-> m_data.ready_res)
        else $error("done pulse while not idle");

    a_poll_released: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_AK_POLL) |-> !sda_enable_reg)
        else $error("SDA driven during acknowledge poll");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_units_reg <= 3'd4)
        else $error("phase length out of range");

    a_bit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_index_reg < 4'd8)
        else $error("bit index out of range");

endmodule

`default_nettype wire
